// ===== sv/tal_pkg.sv =====
// Shared types and codes for the tenant admission limiter.
`default_nettype none

package tal_pkg;

    localparam int TID_W   = 6;
    localparam int TOK_W   = 16;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 8;
    localparam int STAT_W  = 3;
    localparam int LIM_W   = 8;
    localparam int TLIM_W  = 17;
    localparam int CFGI_W  = 2;
    localparam int CFGD_W  = 17;

    localparam logic [STAT_W-1:0] ST_ACCEPTED   = 3'd0;
    localparam logic [STAT_W-1:0] ST_EXPIRED    = 3'd1;
    localparam logic [STAT_W-1:0] ST_TOO_LARGE  = 3'd2;
    localparam logic [STAT_W-1:0] ST_BUSY       = 3'd3;
    localparam logic [STAT_W-1:0] ST_OVERLOADED = 3'd4;
    localparam logic [STAT_W-1:0] ST_RELEASED   = 3'd5;
    localparam logic [STAT_W-1:0] ST_FAULT      = 3'd6;

    localparam logic OP_ADMIT   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [CFGI_W-1:0] CFG_GLOBAL_LIMIT = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_TENANT_LIMIT = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_TOKEN_LIMIT  = 2'd2;

    localparam logic [LIM_W-1:0]  GLOBAL_LIMIT_RST = 8'd16;
    localparam logic [LIM_W-1:0]  TENANT_LIMIT_RST = 8'd4;
    localparam logic [TLIM_W-1:0] TOKEN_LIMIT_RST  = 17'd4096;

    // controller -> datapath
    typedef struct packed {
        logic clear;   // write zero into the next table entry
        logic load;    // capture the request
        logic exec;    // decide, write back, present result
    } tal_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
    } tal_stat_t;

endpackage

`default_nettype wire

// ===== sv/tenant_admission_limiter.sv =====
// Top level of the per-tenant concurrency admission limiter.
`default_nettype none

// After reset the block zeroes every entry of the per-tenant count table
// (busy stays high; configuration writes are taken all the while).
// A request is accepted when start is high and busy is low; each request
// passes capture, table read (the single count table has a registered
// read), and decide and write back, and its one result appears
// on status/tenant_level/global_count with done high for exactly one cycle,
// the cycle after the request finishes. The receiver cannot stall: the
// result must be taken in that cycle. The next request may be started in
// the same cycle the result is shown. cfg_ready is always high; writes to
// unknown register indexes are ignored.
module tenant_admission_limiter
    import tal_pkg::*;
#(
    parameter int TENANTS = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              opcode,
    input  wire logic [TID_W-1:0]  tenant_id,
    input  wire logic [TOK_W-1:0]  prompt_tokens,
    input  wire logic [TOK_W-1:0]  reply_tokens,
    input  wire logic [TIME_W-1:0] deadline_time,
    input  wire logic [TIME_W-1:0] now_time,
    output logic                   done,
    output logic      [STAT_W-1:0] status,
    output logic      [CNT_W-1:0]  tenant_level,
    output logic      [CNT_W-1:0]  global_count,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFGI_W-1:0] cfg_index,
    input  wire logic [CFGD_W-1:0] cfg_data
);

    tal_cmd_t  cmd;
    tal_stat_t stat;

    assign cfg_ready = 1'b1;

    tal_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    tal_dp #(
        .TENANTS (TENANTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .opcode        (opcode),
        .tenant_id     (tenant_id),
        .prompt_tokens (prompt_tokens),
        .reply_tokens  (reply_tokens),
        .deadline_time (deadline_time),
        .now_time      (now_time),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .status        (status),
        .tenant_level  (tenant_level),
        .global_count  (global_count)
    );

endmodule

`default_nettype wire

// ===== sv/tal_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/tal_ctrl.sv =====
// Controller state machine: table clear after reset, then read / execute per request.
`default_nettype none

module tal_ctrl
    import tal_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  tal_stat_t      stat,
    output tal_cmd_t       cmd,
    output logic           busy
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_EXEC  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:  state_next = S_EXEC;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd.clear = (state_reg == S_CLEAR);
        cmd.load  = (state_reg == S_IDLE) && start;
        cmd.exec  = (state_reg == S_EXEC);
        busy      = (state_reg != S_IDLE);
    end

endmodule

`default_nettype wire

// ===== sv/tal_dp.sv =====
// Datapath: limit registers, request capture, count table, admission decision.
`default_nettype none

module tal_dp
    import tal_pkg::*;
#(
    parameter int TENANTS = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  tal_cmd_t               cmd,
    output tal_stat_t              stat,
    input  wire logic              opcode,
    input  wire logic [TID_W-1:0]  tenant_id,
    input  wire logic [TOK_W-1:0]  prompt_tokens,
    input  wire logic [TOK_W-1:0]  reply_tokens,
    input  wire logic [TIME_W-1:0] deadline_time,
    input  wire logic [TIME_W-1:0] now_time,
    input  wire logic              cfg_we,
    input  wire logic [CFGI_W-1:0] cfg_index,
    input  wire logic [CFGD_W-1:0] cfg_data,
    output logic                   done,
    output logic      [STAT_W-1:0] status,
    output logic      [CNT_W-1:0]  tenant_level,
    output logic      [CNT_W-1:0]  global_count
);

    localparam int IDX_W = $clog2(TENANTS);
    localparam int REM_W = IDX_W + 1;

    logic [LIM_W-1:0]  global_limit_reg;
    logic [LIM_W-1:0]  tenant_limit_reg;
    logic [TLIM_W-1:0] token_limit_reg;

    logic              op_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              expired_reg;
    logic              too_large_reg;
    logic [IDX_W-1:0]  clr_cnt_reg;
    logic [CNT_W-1:0]  glob_reg;

    logic              done_reg;
    logic [STAT_W-1:0] status_reg;
    logic [CNT_W-1:0]  tcount_reg;
    logic [CNT_W-1:0]  gcount_reg;

    logic [IDX_W-1:0]  idx_in;
    logic [TLIM_W-1:0] tok_sum;
    logic [CNT_W-1:0]  tcnt;
    logic [STAT_W-1:0] st_next;
    logic [CNT_W-1:0]  tcnt_next;
    logic [CNT_W-1:0]  gcnt_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [CNT_W-1:0]  ram_wdata;

    // tenant_id mod TENANTS by shift-subtract, one step per id bit
    always_comb
    begin
        logic [REM_W-1:0] rem;
        rem = '0;
        for (int i = TID_W - 1; i >= 0; i--)
        begin
            rem = {rem[REM_W-2:0], tenant_id[i]};
            if (rem >= REM_W'(TENANTS))
            begin
                rem = rem - REM_W'(TENANTS);
            end
        end
        idx_in = rem[IDX_W-1:0];
    end

    assign tok_sum = {1'b0, prompt_tokens} + {1'b0, reply_tokens};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            global_limit_reg <= GLOBAL_LIMIT_RST;
            tenant_limit_reg <= TENANT_LIMIT_RST;
            token_limit_reg  <= TOKEN_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GLOBAL_LIMIT: global_limit_reg <= cfg_data[LIM_W-1:0];
                CFG_TENANT_LIMIT: tenant_limit_reg <= cfg_data[LIM_W-1:0];
                CFG_TOKEN_LIMIT:  token_limit_reg  <= cfg_data[TLIM_W-1:0];
                default:          ;
            endcase
        end
    end

    // request capture; the checks that need no table data are done here
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg        <= opcode;
            idx_reg       <= idx_in;
            expired_reg   <= (deadline_time <= now_time);
            too_large_reg <= (tok_sum > token_limit_reg);
        end
    end

    tal_ram #(
        .WIDTH (CNT_W),
        .DEPTH (TENANTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (tcnt)
    );

    always_comb
    begin
        st_next   = ST_ACCEPTED;
        tcnt_next = tcnt;
        gcnt_next = glob_reg;
        if (op_reg == OP_ADMIT)
        begin
            if (expired_reg)
            begin
                st_next = ST_EXPIRED;
            end
            else if (too_large_reg)
            begin
                st_next = ST_TOO_LARGE;
            end
            else if (tcnt >= tenant_limit_reg)
            begin
                st_next = ST_BUSY;
            end
            else if (glob_reg >= global_limit_reg)
            begin
                st_next = ST_OVERLOADED;
            end
            else
            begin
                st_next   = ST_ACCEPTED;
                tcnt_next = tcnt + 8'd1;
                gcnt_next = glob_reg + 8'd1;
            end
        end
        else
        begin
            if (tcnt == '0 || glob_reg == '0)
            begin
                st_next = ST_FAULT;
            end
            else
            begin
                st_next   = ST_RELEASED;
                tcnt_next = tcnt - 8'd1;
                gcnt_next = glob_reg - 8'd1;
            end
        end
    end

    assign ram_we    = cmd.clear || cmd.exec;
    assign ram_waddr = cmd.clear ? clr_cnt_reg : idx_reg;
    assign ram_wdata = cmd.clear ? '0 : tcnt_next;

    assign stat.clear_last = (clr_cnt_reg == IDX_W'(TENANTS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            glob_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.exec)
            begin
                glob_reg <= gcnt_next;
            end
            done_reg <= cmd.exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg <= st_next;
            tcount_reg <= tcnt_next;
            gcount_reg <= gcnt_next;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign tenant_level = tcount_reg;
    assign global_count = gcount_reg;

endmodule

`default_nettype wire
